// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the GGA sentence capture block.
// No dependencies; the bodies are empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: src/ngga_pkg.sv
// Package for the GGA sentence capture block: constants, types and the
// microcode ROM contents. No dependencies.
package ngga_pkg;

	localparam int BUF_DEPTH = 64;
	localparam int BUF_AW    = $clog2(BUF_DEPTH);
	localparam int IDX_W     = BUF_AW + 1;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_G      = 8'h47;
	localparam logic [7:0] CH_P      = 8'h50;
	localparam logic [7:0] CH_A      = 8'h41;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_STAR   = 8'h2A;

	typedef enum logic [3:0] {
		ST_INIT    = 4'd0,
		ST_HUNT    = 4'd1,
		ST_G1      = 4'd2,
		ST_P       = 4'd3,
		ST_G2      = 4'd4,
		ST_G3      = 4'd5,
		ST_A       = 4'd6,
		ST_COMMA   = 4'd7,
		ST_CAPTURE = 4'd8,
		ST_WAIT    = 4'd9
	} parse_st_t;

	typedef enum logic [3:0] {
		S_IDLE     = 4'd0,
		S_DISPATCH = 4'd1,
		S_PARSE    = 4'd2,
		S_CLEAR    = 4'd3,
		S_STATUS   = 4'd4,
		S_BACK     = 4'd5,
		S_RD_ADDR  = 4'd6,
		S_RD_EMIT  = 4'd7,
		S_RD_NEXT  = 4'd8,
		S_RD_DONE  = 4'd9
	} step_t;

	typedef enum logic [2:0] {
		C_NEVER     = 3'd0,
		C_ALWAYS    = 3'd1,
		C_NO_ACCEPT = 3'd2,
		C_CMD_RD    = 3'd3,
		C_NO_CLEAR  = 3'd4,
		C_CNT_MORE  = 3'd5,
		C_OUT_BUSY  = 3'd6
	} cond_t;

	// one microcode word: datapath strobes, then branch condition and target
	typedef struct packed {
		logic  in_rdy;
		logic  parse_en;
		logic  clr_wr;
		logic  rd_issue;
		logic  emit_status;
		logic  emit_rd;
		logic  cnt_inc;
		logic  set_read;
		cond_t cond;
		step_t target;
	} uword_t;

	typedef struct packed {
		logic no_accept;
		logic cmd_rd;
		logic no_clear;
		logic cnt_more;
		logic out_busy;
	} cond_flags_t;

	function automatic logic char_ok(input logic [7:0] c);
		logic ok;
		ok = ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A)) ||
			((c >= 8'h30) && (c <= 8'h39)) || (c == CH_COMMA) ||
			(c == CH_DOLLAR) || (c == CH_DOT) || (c == CH_STAR);
		return ok;
	endfunction

	// Branch: jump to target when cond holds, else fall through to step + 1.
	function automatic uword_t ucode_rom(input step_t s);
		uword_t w;
		w = '0;
		w.cond = C_ALWAYS;
		w.target = S_IDLE;
		unique case (s)
			S_IDLE: begin
				w.in_rdy = 1'b1;
				w.cond = C_NO_ACCEPT;
				w.target = S_IDLE;
			end
			S_DISPATCH: begin
				w.cond = C_CMD_RD;
				w.target = S_RD_ADDR;
			end
			S_PARSE: begin
				w.parse_en = 1'b1;
				w.cond = C_NO_CLEAR;
				w.target = S_STATUS;
			end
			S_CLEAR: begin
				w.clr_wr = 1'b1;
				w.cnt_inc = 1'b1;
				w.cond = C_CNT_MORE;
				w.target = S_CLEAR;
			end
			S_STATUS: begin
				w.emit_status = 1'b1;
				w.cond = C_OUT_BUSY;
				w.target = S_STATUS;
			end
			S_BACK: begin
				w.cond = C_ALWAYS;
				w.target = S_IDLE;
			end
			S_RD_ADDR: begin
				w.rd_issue = 1'b1;
				w.cond = C_NEVER;
				w.target = S_IDLE;
			end
			S_RD_EMIT: begin
				w.emit_rd = 1'b1;
				w.cond = C_OUT_BUSY;
				w.target = S_RD_EMIT;
			end
			S_RD_NEXT: begin
				w.cnt_inc = 1'b1;
				w.cond = C_CNT_MORE;
				w.target = S_RD_ADDR;
			end
			S_RD_DONE: begin
				w.set_read = 1'b1;
				w.cond = C_ALWAYS;
				w.target = S_IDLE;
			end
			default: begin
				w.cond = C_ALWAYS;
				w.target = S_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

// File: src/ngga_if.sv
// Channel interfaces of the GGA sentence capture block: request, result
// and register write. No dependencies.
interface ngga_req_if;
	logic       valid;
	logic       ready;
	logic       cmd;
	logic [7:0] rx_byte;
	modport source (output valid, cmd, rx_byte, input ready);
	modport sink (input valid, cmd, rx_byte, output ready);
endinterface

interface ngga_rsp_if;
	logic       valid;
	logic       ready;
	logic       is_readout;
	logic [7:0] out_byte;
	logic       last;
	logic       good_data;
	modport source (output valid, is_readout, out_byte, last, good_data, input ready);
	modport sink (input valid, is_readout, out_byte, last, good_data, output ready);
endinterface

interface ngga_cfg_if;
	logic valid;
	logic ready;
	logic rx_enable;
	modport source (output valid, rx_enable, input ready);
	modport sink (input valid, rx_enable, output ready);
endinterface

// File: src/nmea_gga_sentence_capture.sv
// Received byte: one status result after acceptance; a byte that triggers
// a buffer clear first sweeps all 64 entries, one entry per cycle.
// Readout: 64 results, each through address, load and advance steps on the
// single read port of the sentence memory; a busy output holds the steps.
// One item at a time. Async reset (arst_n low) clears control and the
// entry valid bits; unwritten entries read as zero, rx_enable resets to 0.
module nmea_gga_sentence_capture
	import ngga_pkg::*;
(
	input logic         clk,
	input logic         arst_n,
	ngga_req_if.sink    req,
	ngga_rsp_if.source  rsp,
	ngga_cfg_if.sink    cfg
);
`include "assert_macros.svh"

	// sequencer
	uword_t      ctl;
	cond_flags_t flags;

	// latched request
	logic       cmd_q;
	logic [7:0] byte_q;

	// register and parse state
	logic             rx_en_q;
	parse_st_t        pstate_q;
	parse_st_t        pstate_d;
	logic [IDX_W-1:0] widx_q;
	logic             good_q;
	logic             read_q;

	// sweep counter, shared by the clear pass and the readout
	logic [BUF_AW-1:0] cnt_q;
	logic              cnt_more;

	// sentence memory, with a valid bit per entry for the all-zero reset value
	logic [7:0]           sent_mem [BUF_DEPTH];
	logic [BUF_DEPTH-1:0] ent_vld_q;
	logic [7:0]           rd_data_q;
	logic                 rd_vld_q;
	logic                 mem_we;
	logic [BUF_AW-1:0]    mem_addr;
	logic [7:0]           mem_wdata;

	// parse actions
	logic take;
	logic clr_need;
	logic cap_wr;
	logic widx_zero;
	logic widx_inc;
	logic good_set;
	logic good_clr;
	logic read_clr;

	// output register
	logic       out_vld_q;
	logic       out_isrd_q;
	logic [7:0] out_byte_q;
	logic       out_last_q;
	logic       out_good_q;
	logic       out_free;
	logic       ld_status;
	logic       ld_rd;

	ngga_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.ctl    (ctl)
	);

	assign req.ready = ctl.in_rdy;
	assign cfg.ready = 1'b1;

	assign out_free  = !out_vld_q || rsp.ready;
	assign ld_status = ctl.emit_status && out_free;
	assign ld_rd     = ctl.emit_rd && out_free;
	assign cnt_more  = (cnt_q != BUF_AW'(BUF_DEPTH - 1));

	always_comb begin
		flags.no_accept = !req.valid;
		flags.cmd_rd    = cmd_q;
		flags.no_clear  = !clr_need;
		flags.cnt_more  = cnt_more;
		flags.out_busy  = !out_free;
	end

	// a byte counts only when enabled and in the accepted character set
	assign take = rx_en_q && char_ok(byte_q);

	// header match / capture state machine: next state
	always_comb begin
		pstate_d = pstate_q;
		if (take) begin
			unique case (pstate_q)
				ST_INIT:    pstate_d = ST_HUNT;
				ST_HUNT:    pstate_d = (byte_q == CH_DOLLAR) ? ST_G1 : ST_HUNT;
				ST_G1:      pstate_d = (byte_q == CH_G) ? ST_P : ST_HUNT;
				ST_P:       pstate_d = (byte_q == CH_P) ? ST_G2 : ST_HUNT;
				ST_G2:      pstate_d = (byte_q == CH_G) ? ST_G3 : ST_HUNT;
				ST_G3:      pstate_d = (byte_q == CH_G) ? ST_A : ST_HUNT;
				ST_A:       pstate_d = (byte_q == CH_A) ? ST_COMMA : ST_HUNT;
				ST_COMMA:   pstate_d = (byte_q == CH_COMMA) ? ST_CAPTURE : ST_HUNT;
				ST_CAPTURE: pstate_d = (byte_q == CH_DOLLAR) ? ST_WAIT : ST_CAPTURE;
				ST_WAIT:    pstate_d = read_q ? ST_HUNT : ST_WAIT;
				default:    pstate_d = ST_HUNT;
			endcase
		end
	end

	// header match / capture state machine: actions
	always_comb begin
		clr_need  = 1'b0;
		cap_wr    = 1'b0;
		widx_zero = 1'b0;
		widx_inc  = 1'b0;
		good_set  = 1'b0;
		good_clr  = 1'b0;
		read_clr  = 1'b0;
		if (take) begin
			unique case (pstate_q)
				ST_INIT: begin
					clr_need  = 1'b1;
					read_clr  = 1'b1;
					widx_zero = 1'b1;
				end
				ST_HUNT: begin
				end
				ST_G1: read_clr = (byte_q != CH_G);
				ST_P:  read_clr = (byte_q != CH_P);
				ST_G2: read_clr = (byte_q != CH_G);
				ST_G3: read_clr = (byte_q != CH_G);
				ST_A: begin
					clr_need = (byte_q == CH_A);
					read_clr = (byte_q != CH_A);
				end
				ST_COMMA: begin
					widx_zero = (byte_q == CH_COMMA);
					read_clr  = (byte_q != CH_COMMA);
				end
				ST_CAPTURE: begin
					// past the end of the buffer bytes are dropped, index saturates
					cap_wr   = (widx_q < IDX_W'(BUF_DEPTH));
					widx_inc = cap_wr;
					good_set = (byte_q == CH_DOLLAR);
				end
				ST_WAIT: begin
					good_clr = read_q;
					read_clr = read_q;
					clr_need = read_q;
				end
				default: read_clr = 1'b1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_en_q  <= 1'b0;
			pstate_q <= ST_INIT;
			widx_q   <= '0;
			good_q   <= 1'b1;
			read_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (cfg.valid) begin
				rx_en_q <= cfg.rx_enable;
			end
			if (ctl.parse_en) begin
				pstate_q <= pstate_d;
				if (widx_zero) begin
					widx_q <= '0;
				end else if (widx_inc) begin
					widx_q <= widx_q + IDX_W'(1);
				end
				if (good_set) begin
					good_q <= 1'b1;
				end else if (good_clr) begin
					good_q <= 1'b0;
				end
				if (read_clr) begin
					read_q <= 1'b0;
				end
			end
			if (ctl.set_read) begin
				read_q <= 1'b1;
			end
			// wraps back to zero at the end of every sweep
			if (ctl.cnt_inc) begin
				cnt_q <= cnt_q + BUF_AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_q  <= req.cmd;
			byte_q <= req.rx_byte;
		end
	end

	// single write port: clear sweep or captured byte
	assign mem_we    = ctl.clr_wr || (ctl.parse_en && cap_wr);
	assign mem_addr  = ctl.clr_wr ? cnt_q : widx_q[BUF_AW-1:0];
	assign mem_wdata = ctl.clr_wr ? CH_DOLLAR : byte_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			sent_mem[mem_addr] <= mem_wdata;
		end
		if (ctl.rd_issue) begin
			rd_data_q <= sent_mem[cnt_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (mem_we) begin
				ent_vld_q[mem_addr] <= 1'b1;
			end
			if (ctl.rd_issue) begin
				rd_vld_q <= ent_vld_q[cnt_q];
			end
		end
	end

	// result register: parts the sequencer from the consumer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (ld_status || ld_rd) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_status) begin
			out_isrd_q <= 1'b0;
			out_byte_q <= '0;
			out_last_q <= 1'b1;
			out_good_q <= good_q;
		end else if (ld_rd) begin
			out_isrd_q <= 1'b1;
			out_byte_q <= rd_vld_q ? rd_data_q : 8'h00;
			out_last_q <= !cnt_more;
			out_good_q <= good_q;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.is_readout = out_isrd_q;
	assign rsp.out_byte   = out_byte_q;
	assign rsp.last       = out_last_q;
	assign rsp.good_data  = out_good_q;

	`ASSERT_IMPLY(a_idle_cnt_zero, clk, arst_n, req.ready, cnt_q == '0)
	`ASSERT_ALWAYS(a_widx_bound, clk, arst_n, widx_q <= IDX_W'(BUF_DEPTH))
	`ASSERT_IMPLY(a_good_fall, clk, arst_n, $fell(good_q), $past(pstate_q) == ST_WAIT)
	`ASSERT_IMPLY(a_read_after_last, clk, arst_n, ctl.set_read, out_last_q && out_isrd_q)

endmodule

// File: src/ngga_seq.sv
// Microcode sequencer: step counter, control ROM and branch evaluation.
// Depends on ngga_pkg.
module ngga_seq
	import ngga_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cond_flags_t flags,
	output uword_t      ctl
);

	step_t step_q;
	step_t step_d;
	logic  take;

	always_comb begin
		case (ctl.cond)
			C_NEVER:     take = 1'b0;
			C_ALWAYS:    take = 1'b1;
			C_NO_ACCEPT: take = flags.no_accept;
			C_CMD_RD:    take = flags.cmd_rd;
			C_NO_CLEAR:  take = flags.no_clear;
			C_CNT_MORE:  take = flags.cnt_more;
			C_OUT_BUSY:  take = flags.out_busy;
			default:     take = 1'b1;
		endcase
	end

	// next step
	always_comb begin
		step_d = take ? ctl.target : step_t'(step_q + 4'd1);
	end

	// control word of the current step
	always_comb begin
		ctl = ucode_rom(step_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= S_IDLE;
		end else begin
			step_q <= step_d;
		end
	end

endmodule

// File: sim/nmea_gga_sentence_capture_test.sv
// Self-checking testbench for nmea_gga_sentence_capture: directed and random
// byte streams with a scoreboard that predicts every result transfer.
// Depends on ngga_pkg (src/ngga_pkg.sv) and the channel interfaces (src/ngga_if.sv).
module nmea_gga_sentence_capture_test;
	import ngga_pkg::*;

	// run limit in clock cycles
	localparam int CYCLE_LIMIT = 1000000;
	// quiet cycles after the last result before touching the register or ending
	localparam int SETTLE_CYCLES = 10;
	localparam int TAIL_CYCLES = 20;
	localparam int MAX_SHOWN = 10;

	// one result transfer as seen on the rsp channel
	typedef struct packed {
		logic       is_readout;
		logic [7:0] out_byte;
		logic       last;
		logic       good_data;
	} gga_result_t;

	// Predicts the block from accepted requests and checks each result transfer
	// against the oldest prediction.
	class gga_capture_scoreboard;
		gga_result_t pending_results[$];
		logic [7:0]  sentence_mem[BUF_DEPTH];
		parse_st_t   parse_st;
		logic [6:0]  wr_idx;
		logic        good;
		logic        was_read;
		logic        rx_on;
		int          errors;
		int          shown;

		function new();
			parse_st = ST_INIT;
			wr_idx = '0;
			good = 1'b1;
			was_read = 1'b0;
			rx_on = 1'b0;
			foreach (sentence_mem[i]) sentence_mem[i] = 8'h00;
			errors = 0;
			shown = 0;
		endfunction

		function void fill_dollars();
			foreach (sentence_mem[i]) sentence_mem[i] = CH_DOLLAR;
		endfunction

		function bit nmea_char(logic [7:0] c);
			return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
				(c >= "0" && c <= "9") || c == CH_COMMA || c == CH_DOLLAR ||
				c == CH_DOT || c == CH_STAR;
		endfunction

		function void restart_hunt();
			parse_st = ST_HUNT;
			was_read = 1'b0;
		endfunction

		function void parse_byte(logic [7:0] c);
			if (!nmea_char(c))
				return;
			case (parse_st)
				ST_INIT: begin
					fill_dollars();
					restart_hunt();
					wr_idx = '0;
				end
				ST_HUNT: begin
					if (c == CH_DOLLAR) parse_st = ST_G1;
				end
				ST_G1: begin
					if (c == CH_G) parse_st = ST_P; else restart_hunt();
				end
				ST_P: begin
					if (c == CH_P) parse_st = ST_G2; else restart_hunt();
				end
				ST_G2: begin
					if (c == CH_G) parse_st = ST_G3; else restart_hunt();
				end
				ST_G3: begin
					if (c == CH_G) parse_st = ST_A; else restart_hunt();
				end
				ST_A: begin
					if (c == CH_A) begin
						parse_st = ST_COMMA;
						fill_dollars();
					end else begin
						restart_hunt();
					end
				end
				ST_COMMA: begin
					if (c == CH_COMMA) begin
						parse_st = ST_CAPTURE;
						wr_idx = '0;
					end else begin
						restart_hunt();
					end
				end
				ST_CAPTURE: begin
					// saturates at the buffer end; the closing '$' still ends capture
					if (wr_idx < BUF_DEPTH) begin
						sentence_mem[wr_idx] = c;
						wr_idx = wr_idx + 7'd1;
					end
					if (c == CH_DOLLAR) begin
						good = 1'b1;
						parse_st = ST_WAIT;
					end
				end
				ST_WAIT: begin
					if (was_read) begin
						good = 1'b0;
						restart_hunt();
						fill_dollars();
					end
				end
				default: begin
					restart_hunt();
				end
			endcase
		endfunction

		// expected results of one accepted request
		function void predict_item(logic cmd, logic [7:0] c);
			gga_result_t r;
			if (cmd) begin
				for (int i = 0; i < BUF_DEPTH; i++) begin
					r.is_readout = 1'b1;
					r.out_byte = sentence_mem[i];
					r.last = (i == BUF_DEPTH - 1);
					r.good_data = good;
					pending_results.push_back(r);
				end
				was_read = 1'b1;
			end else begin
				if (rx_on) parse_byte(c);
				r.is_readout = 1'b0;
				r.out_byte = 8'h00;
				r.last = 1'b1;
				r.good_data = good;
				pending_results.push_back(r);
			end
		endfunction

		function void flag_error(string what, gga_result_t want, gga_result_t got);
			errors++;
			if (shown < MAX_SHOWN) begin
				shown++;
				$write("%s: expected ro=%0d byte=%02h last=%0d good=%0d, ",
					what, want.is_readout, want.out_byte, want.last, want.good_data);
				$display("got ro=%0d byte=%02h last=%0d good=%0d",
					got.is_readout, got.out_byte, got.last, got.good_data);
			end
		endfunction

		function void check_result(gga_result_t got);
			gga_result_t want;
			if (pending_results.size() == 0) begin
				flag_error("unexpected result", '0, got);
				return;
			end
			want = pending_results.pop_front();
			if (got.is_readout !== want.is_readout || got.out_byte !== want.out_byte ||
				got.last !== want.last || got.good_data !== want.good_data)
				flag_error("result mismatch", want, got);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   tx_idle_pct = 24;
	int   rx_idle_pct = 61;
	int   items_sent = 0;
	int   cycles = 0;

	ngga_req_if req();
	ngga_rsp_if rsp();
	ngga_cfg_if cfg();

	gga_capture_scoreboard sb = new();

	nmea_gga_sentence_capture dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp),
		.cfg    (cfg)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// result side back-pressure: random stall per cycle at the current rate
	always @(posedge clk) begin
		rsp.ready <= ($urandom_range(99) >= rx_idle_pct);
	end

	// Monitor: all sampling at the rising edge sees pre-edge values, since
	// every driver here and the DUT update through nonblocking assignments.
	always @(posedge clk) begin
		if (arst_n) begin
			if (req.valid === 1'b1 && req.ready === 1'b1)
				sb.predict_item(req.cmd, req.rx_byte);
			if (rsp.valid === 1'b1 && rsp.ready === 1'b1)
				sb.check_result(gga_result_t'{rsp.is_readout, rsp.out_byte,
					rsp.last, rsp.good_data});
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// One request transfer. valid stays high into the next request when no
	// idle gap is drawn, so it is never dropped and raised in the same step.
	task automatic send_item(logic cmd, logic [7:0] b);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap != 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req.valid <= 1'b1;
		req.cmd <= cmd;
		req.rx_byte <= b;
		do @(posedge clk); while (req.ready !== 1'b1);
		items_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			send_item(1'b0, s[i]);
	endtask

	// Stop sending until every predicted result has been seen, then let
	// the block settle back to idle. It first waits for the clock, so the
	// monitor has logged the last transfer.
	task automatic hold_until_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// register write, only with the block idle
	task automatic write_enable(logic v);
		hold_until_drained();
		cfg.valid <= 1'b1;
		cfg.rx_enable <= v;
		do @(posedge clk); while (cfg.ready !== 1'b1);
		cfg.valid <= 1'b0;
		sb.rx_on = v;
	endtask

	// mostly legal sentence characters, some arbitrary bytes
	function automatic logic [7:0] pick_body_byte();
		int r;
		r = $urandom_range(9);
		if (r < 4)
			return 8'h30 + 8'($urandom_range(9));
		if (r < 5)
			return 8'h41 + 8'($urandom_range(25));
		if (r < 6)
			return 8'h61 + 8'($urandom_range(25));
		if (r < 8) begin
			case ($urandom_range(2))
				0: return CH_COMMA;
				1: return CH_DOT;
				default: return CH_STAR;
			endcase
		end
		return 8'($urandom_range(255));
	endfunction

	// One random episode: mostly a full sentence with random body, else
	// a truncated header or a stray readout as noise.
	task automatic random_sentence(bit go_long);
		int kind;
		int len;
		int n;
		string hdr;
		hdr = "$GPGGA,";
		kind = $urandom_range(9);
		repeat ($urandom_range(2)) send_item(1'b0, 8'($urandom_range(255)));
		if (go_long || kind < 7) begin
			send_text(hdr);
			// long bodies run past the buffer end and exercise the overrun path
			if (go_long)
				len = $urandom_range(64, 67);
			else if ($urandom_range(19) == 0)
				len = $urandom_range(50, 70);
			else
				len = $urandom_range(8);
			repeat (len) send_item(1'b0, pick_body_byte());
			send_item(1'b0, CH_DOLLAR);
			if ($urandom_range(9) < 7)
				send_item(1'b1, 8'($urandom_range(255)));
			// first legal byte after a readout restarts the hunt
			repeat ($urandom_range(2)) send_item(1'b0, pick_body_byte());
		end else if (kind < 9) begin
			n = $urandom_range(1, 6);
			for (int i = 0; i < n; i++)
				send_item(1'b0, hdr[i]);
			send_item(1'b0, pick_body_byte());
		end else begin
			send_item(1'b1, 8'($urandom_range(255)));
		end
	endtask

	initial begin
		int target;
		bit mid_done;
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.cmd = 1'b0;
		req.rx_byte = 8'h00;
		rsp.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.rx_enable = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: readout of reset contents and a byte ignored while disabled
		send_item(1'b1, 8'h00);
		send_item(1'b0, CH_DOLLAR);
		write_enable(1'b1);
		// illegal characters are dropped, first legal one leaves init and clears
		send_item(1'b0, 8'h00);
		send_item(1'b0, 8'hFF);
		send_item(1'b0, "a");
		// '$' while expecting 'G' is a mismatch, not a new start
		send_item(1'b0, CH_DOLLAR);
		send_item(1'b0, CH_DOLLAR);
		send_text("$GPGGA,0Z.*$");
		// wait state: ignored before readout, clears good_data after it
		send_item(1'b0, "q");
		send_item(1'b1, 8'hFF);
		send_item(1'b0, "9");

		// random phases with different stall patterns
		for (int p = 0; p < 3; p++) begin
			case (p)
				0: begin
					tx_idle_pct = 24;
					rx_idle_pct = 61;
				end
				1: begin
					tx_idle_pct = 61;
					rx_idle_pct = 24;
				end
				default: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
			endcase
			write_enable(1'b1);
			target = items_sent + 115;
			mid_done = 1'b0;
			if (p == 1)
				random_sentence(1'b1);
			while (items_sent < target) begin
				random_sentence(1'b0);
				// disabled stretch: bytes ignored, readout still served
				if (!mid_done && items_sent > target - 60) begin
					write_enable(1'b0);
					repeat (4) send_item(1'b0, pick_body_byte());
					send_item(1'b1, 8'($urandom_range(255)));
					write_enable(1'b1);
					mid_done = 1'b1;
				end
			end
		end

		hold_until_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (sb.errors == 0 && sb.pending_results.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// File: nmea_gga_sentence_capture.f
+incdir+src
src/ngga_pkg.sv
src/ngga_if.sv
src/ngga_seq.sv
src/nmea_gga_sentence_capture.sv
sim/nmea_gga_sentence_capture_test.sv
